// File: sv/hbos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbos_pkg
// Shared widths, command codes and the word store request type for the
// two-level bitmap ordered set.
// ----------------------------------------------------------------------------
package hbos_pkg;

  localparam int KEY_W   = 12;
  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;
  localparam int ADDR_W  = KEY_W - BIT_W;
  localparam int DEPTH   = 1 << ADDR_W;

  localparam logic [2:0] CMD_CONTAINS = 3'd0;
  localparam logic [2:0] CMD_INSERT   = 3'd1;
  localparam logic [2:0] CMD_ERASE    = 3'd2;
  localparam logic [2:0] CMD_GE       = 3'd3;
  localparam logic [2:0] CMD_GT       = 3'd4;
  localparam logic [2:0] CMD_LE       = 3'd5;
  localparam logic [2:0] CMD_LT       = 3'd6;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              sum_set;
    logic              sum_clr;
  } store_req_t;

endpackage

// File: sv/hbos_bit_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbos_bit_scan
// Masks a 64-bit occupancy word at a bit position and finds the nearest
// set bit upward (lowest at or above) or downward (highest at or below).
// ----------------------------------------------------------------------------
module hbos_bit_scan import hbos_pkg::*; (
  input  logic [WORD_W-1:0] word_i,
  input  logic [BIT_W-1:0]  pos_i,
  input  logic              up_i,
  output logic              hit_o,
  output logic [BIT_W-1:0]  idx_o
);

  logic [WORD_W-1:0] masked;

  always_comb begin
    if (up_i) begin
      masked = word_i & ({WORD_W{1'b1}} << pos_i);
    end else begin
      masked = word_i & ~((~WORD_W'(1)) << pos_i);
    end
  end

  assign hit_o = |masked;

  always_comb begin
    idx_o = '0;
    if (up_i) begin
      for (int i = WORD_W - 1; i >= 0; i--) begin
        if (masked[i]) idx_o = BIT_W'(i);
      end
    end else begin
      for (int i = 0; i < WORD_W; i++) begin
        if (masked[i]) idx_o = BIT_W'(i);
      end
    end
  end

endmodule

// File: sv/hbos_word_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbos_word_store
// Leaf occupancy memory (one read, one write port, registered read data)
// with per-entry valid bits, plus the summary word register.
// ----------------------------------------------------------------------------
module hbos_word_store import hbos_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  store_req_t        req_i,
  output logic [WORD_W-1:0] rd_data_o,
  output logic [WORD_W-1:0] summary_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  entry_valid_q;
  logic [WORD_W-1:0] rd_word_q;
  logic              rd_valid_q;
  logic [WORD_W-1:0] summary_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_word_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      rd_valid_q    <= 1'b0;
      summary_q     <= '0;
    end else begin
      if (req_i.wr_en) begin
        entry_valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= entry_valid_q[req_i.rd_addr];
      end
      if (req_i.sum_set) begin
        summary_q[req_i.wr_addr] <= 1'b1;
      end else if (req_i.sum_clr) begin
        summary_q[req_i.wr_addr] <= 1'b0;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_word_q : '0;
  assign summary_o = summary_q;

  // read and write never target the memory in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.rd_en && req_i.wr_en))
    else $error("word store read and write overlap");

  // summary updates only come with a leaf write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.sum_set || req_i.sum_clr) |-> req_i.wr_en)
    else $error("summary update without leaf write");

  // a cleared summary bit matches an all-zero leaf word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.sum_clr |-> (req_i.wr_data == '0))
    else $error("summary cleared for non-empty leaf");

endmodule

// File: sv/hierarchical_bitmap_ordered_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_bitmap_ordered_set
// Ordered set of 12-bit keys held as 64 leaf occupancy words and one
// summary word; membership, insert, erase and successor/predecessor search.
// ----------------------------------------------------------------------------
// One item is in flight at a time. Contains, insert, erase and searches that
// resolve in the key's own leaf word go through ST_LEAF1 and ST_PUSH to the
// result register; searches that go through the summary word also pass
// ST_LEAF2, as they need two dependent reads through the single read port
// of the leaf memory, whose read data is registered. A new item is accepted
// as soon as the previous one has moved into the output register, even while
// that result is still stalled. Insert and erase return found=0, position=0.
// The set is empty after reset.
module hierarchical_bitmap_ordered_set import hbos_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       in_cmd_i,
  input  logic [KEY_W-1:0] in_key_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             out_found_o,
  output logic [KEY_W-1:0] out_position_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LEAF1 = 2'd1;
  localparam logic [1:0] ST_LEAF2 = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [2:0]        cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  v_q, v_d;
  logic              none_q, none_d;
  logic              up_q, up_d;
  logic [ADDR_W-1:0] hi_q, hi_d;
  logic              pend_found_q, pend_found_d;
  logic [KEY_W-1:0]  pend_pos_q, pend_pos_d;
  logic              out_valid_q;
  logic              out_found_q;
  logic [KEY_W-1:0]  out_pos_q;

  store_req_t        req;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] summary;
  logic              accept;
  logic              push;

  logic [BIT_W-1:0]  leaf_pos;
  logic              leaf_hit;
  logic [BIT_W-1:0]  leaf_idx;
  logic [ADDR_W-1:0] sum_pos;
  logic              sum_hit;
  logic [ADDR_W-1:0] sum_idx;
  logic              sum_ok;
  logic [BIT_W-1:0]  bit_sel;
  logic [KEY_W:0]    key_inc;

  assign accept     = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign push       = (state_q == ST_PUSH) && (!out_valid_q || !out_stall_i);
  assign bit_sel    = key_q[BIT_W-1:0];
  assign key_inc    = {1'b0, in_key_i} + (KEY_W + 1)'(1);

  hbos_word_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_data),
    .summary_o (summary)
  );

  always_comb begin
    if (state_q == ST_LEAF2) begin
      leaf_pos = up_q ? '0 : '1;
    end else begin
      leaf_pos = v_q[BIT_W-1:0];
    end
  end

  hbos_bit_scan u_leaf_scan (
    .word_i (rd_data),
    .pos_i  (leaf_pos),
    .up_i   (up_q),
    .hit_o  (leaf_hit),
    .idx_o  (leaf_idx)
  );

  assign sum_pos = up_q ? v_q[KEY_W-1:BIT_W] + ADDR_W'(1)
                        : v_q[KEY_W-1:BIT_W] - ADDR_W'(1);
  assign sum_ok  = up_q ? (v_q[KEY_W-1:BIT_W] != '1) : (v_q[KEY_W-1:BIT_W] != '0);

  hbos_bit_scan u_sum_scan (
    .word_i (summary),
    .pos_i  (sum_pos),
    .up_i   (up_q),
    .hit_o  (sum_hit),
    .idx_o  (sum_idx)
  );

  // search start point and direction at accept
  always_comb begin
    v_d    = in_key_i;
    none_d = 1'b0;
    up_d   = 1'b0;
    case (in_cmd_i)
      CMD_GE: begin
        up_d = 1'b1;
      end
      CMD_GT: begin
        up_d   = 1'b1;
        v_d    = key_inc[KEY_W-1:0];
        none_d = key_inc[KEY_W];
      end
      CMD_LT: begin
        v_d    = in_key_i - KEY_W'(1);
        none_d = (in_key_i == '0);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    hi_d         = hi_q;
    pend_found_d = pend_found_q;
    pend_pos_d   = pend_pos_q;
    req          = '0;
    req.wr_addr  = key_q[KEY_W-1:BIT_W];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req.rd_en   = 1'b1;
          req.rd_addr = v_d[KEY_W-1:BIT_W];
          state_d     = ST_LEAF1;
        end
      end
      ST_LEAF1: begin
        pend_found_d = 1'b0;
        pend_pos_d   = '0;
        state_d      = ST_PUSH;
        case (cmd_q) inside
          CMD_CONTAINS: begin
            pend_found_d = rd_data[bit_sel];
          end
          CMD_INSERT: begin
            req.wr_en   = 1'b1;
            req.wr_data = rd_data | (WORD_W'(1) << bit_sel);
            req.sum_set = 1'b1;
          end
          CMD_ERASE: begin
            req.wr_en   = 1'b1;
            req.wr_data = rd_data & ~(WORD_W'(1) << bit_sel);
            req.sum_clr = (req.wr_data == '0);
          end
          CMD_GE, CMD_GT, CMD_LE, CMD_LT: begin
            if (!none_q) begin
              if (leaf_hit) begin
                pend_found_d = 1'b1;
                pend_pos_d   = {v_q[KEY_W-1:BIT_W], leaf_idx};
              end else if (sum_ok && sum_hit) begin
                req.rd_en   = 1'b1;
                req.rd_addr = sum_idx;
                hi_d        = sum_idx;
                state_d     = ST_LEAF2;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_LEAF2: begin
        pend_found_d = 1'b1;
        pend_pos_d   = {hi_q, leaf_idx};
        state_d      = ST_PUSH;
      end
      ST_PUSH: begin
        if (push) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_cmd_i;
      key_q  <= in_key_i;
      v_q    <= v_d;
      none_q <= none_d;
      up_q   <= up_d;
    end
    hi_q         <= hi_d;
    pend_found_q <= pend_found_d;
    pend_pos_q   <= pend_pos_d;
    if (push) begin
      out_found_q <= pend_found_q;
      out_pos_q   <= pend_pos_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_found_o    = out_found_q;
  assign out_position_o = out_pos_q;

  // a set summary bit always points at a non-empty leaf word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEAF2) |-> (rd_data != '0))
    else $error("summary bit set for empty leaf word");

  // a result without a hit carries position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_found_o) |-> (out_position_o == '0))
    else $error("non-zero position without hit");

  // every accepted beat starts with a leaf read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_LEAF1))
    else $error("accepted beat did not start leaf read");

endmodule

// File: tb/tb_hierarchical_bitmap_ordered_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hierarchical_bitmap_ordered_set
// Self-checking bench for the two-level bitmap ordered set. A clocked driver
// feeds command/key beats from a pending queue; a clocked monitor checks each
// result beat against a flat membership image of the set kept by the bench.
// Runs a directed opener, then random traffic clustered on a few leaf words
// under several sender/receiver idling mixes, a long receiver hold-off, and
// a final erase-all pass with searches on the emptied set.
// ----------------------------------------------------------------------------
module tb_hierarchical_bitmap_ordered_set;
  import hbos_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 80;

  typedef struct {
    logic [2:0]       cmd;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct {
    logic             found;
    logic [KEY_W-1:0] position;
  } answer_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [2:0]       in_cmd_i = CMD_CONTAINS;
  logic [KEY_W-1:0] in_key_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             out_found_o;
  logic [KEY_W-1:0] out_position_o;

  request_t          request_q[$];
  answer_t           answer_q[$];
  logic [WORD_W-1:0] member_words [DEPTH];
  int                hot_words [4];
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                hold_trigger = 0;
  int                hold_served = 0;
  int                hold_left = 0;
  int                error_count = 0;

  hierarchical_bitmap_ordered_set dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_cmd_i       (in_cmd_i),
    .in_key_i       (in_key_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_found_o    (out_found_o),
    .out_position_o (out_position_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("** hierarchical_bitmap_ordered_set: FAILED **");
    $finish;
  end

  function automatic bit is_member(int k);
    return member_words[k >> BIT_W][k % WORD_W];
  endfunction

  // smallest member at or above start, -1 if none
  function automatic int scan_up(int start);
    for (int k = start; k < DEPTH * WORD_W; k++) begin
      if (is_member(k)) return k;
    end
    return -1;
  endfunction

  // largest member at or below start, -1 if none
  function automatic int scan_down(int start);
    for (int k = start; k >= 0; k--) begin
      if (is_member(k)) return k;
    end
    return -1;
  endfunction

  function automatic answer_t set_op_result(request_t req);
    answer_t res;
    int      k;
    int      hit;
    res.found = 1'b0;
    res.position = '0;
    k = int'(req.key);
    hit = -1;
    case (req.cmd)
      CMD_CONTAINS: res.found = is_member(k);
      CMD_INSERT:   member_words[k >> BIT_W][k % WORD_W] = 1'b1;
      CMD_ERASE:    member_words[k >> BIT_W][k % WORD_W] = 1'b0;
      CMD_GE:       hit = scan_up(k);
      CMD_GT:       hit = scan_up(k + 1);
      CMD_LE:       hit = scan_down(k);
      CMD_LT:       hit = scan_down(k - 1);
      default: ;
    endcase
    if (hit >= 0) begin
      res.found = 1'b1;
      res.position = hit[KEY_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : driver
    request_t nxt;
    request_t sent;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_cmd_i <= CMD_CONTAINS;
      in_key_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        sent.cmd = in_cmd_i;
        sent.key = in_key_i;
        answer_q = {answer_q, set_op_result(sent)};
      end
      if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = request_q.pop_front();
        in_valid_i <= 1'b1;
        in_cmd_i <= nxt.cmd;
        in_key_i <= nxt.key;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    answer_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got found=%0b position=%0d",
                   $time, out_found_o, out_position_o);
          error_count++;
        end else begin
          want = answer_q.pop_front();
          if (out_found_o !== want.found) begin
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, want.found, out_found_o);
            error_count++;
          end
          if (out_position_o !== want.position) begin
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, want.position, out_position_o);
            error_count++;
          end
        end
      end
      if (hold_trigger != hold_served) begin
        hold_served <= hold_trigger;
        hold_left <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  task automatic queue_beat(logic [2:0] cmd, int key);
    request_t req;
    req.cmd = cmd;
    req.key = key[KEY_W-1:0];
    request_q = {request_q, req};
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || answer_q.size() != 0);
  endtask

  function automatic int pick_key();
    int w;
    w = hot_words[$urandom_range(0, 3)];
    case ($urandom_range(0, 9)) inside
      [0:2]: return $urandom_range(0, DEPTH * WORD_W - 1);
      [3:6]: return w * WORD_W + $urandom_range(0, WORD_W - 1);
      [7:8]: return w * WORD_W + ($urandom_range(0, 1) ? WORD_W - 1 : 0);
      default: return $urandom_range(0, 1) ? DEPTH * WORD_W - 1 : 0;
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd(int insert_pct, int erase_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return CMD_INSERT;
    if (r < insert_pct + erase_pct) return CMD_ERASE;
    if (r < insert_pct + erase_pct + 12) return CMD_CONTAINS;
    case ($urandom_range(0, 3))
      0: return CMD_GE;
      1: return CMD_GT;
      2: return CMD_LE;
      default: return CMD_LT;
    endcase
  endfunction

  initial begin
    int idle_mix [4][2];
    int ins_pct;
    int era_pct;
    idle_mix = '{'{0, 0}, '{47, 0}, '{0, 47}, '{29, 29}};
    for (int i = 0; i < DEPTH; i++) member_words[i] = '0;
    @(posedge rst_ni);

    // empty set, word edges and both ends of the key range
    queue_beat(CMD_GE, 0);
    queue_beat(CMD_LE, DEPTH * WORD_W - 1);
    queue_beat(CMD_LT, 0);
    queue_beat(CMD_CONTAINS, 0);
    queue_beat(CMD_INSERT, 0);
    queue_beat(CMD_INSERT, 63);
    queue_beat(CMD_INSERT, 64);
    queue_beat(CMD_INSERT, 2048);
    queue_beat(CMD_INSERT, DEPTH * WORD_W - 1);
    queue_beat(CMD_CONTAINS, 63);
    queue_beat(CMD_CONTAINS, 62);
    queue_beat(CMD_GE, 1);
    queue_beat(CMD_GT, 63);
    queue_beat(CMD_GT, 64);
    queue_beat(CMD_LE, DEPTH * WORD_W - 2);
    queue_beat(CMD_LT, 64);
    queue_beat(CMD_GT, DEPTH * WORD_W - 1);
    queue_beat(CMD_GE, DEPTH * WORD_W - 1);
    queue_beat(CMD_LE, 0);
    queue_beat(CMD_LT, 0);
    queue_beat(CMD_UNUSED, 5);
    queue_beat(CMD_ERASE, 64);
    queue_beat(CMD_LT, 2048);
    queue_beat(CMD_ERASE, 0);
    queue_beat(CMD_ERASE, 63);
    queue_beat(CMD_LE, 62);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mix[p][0];
      recv_stall_pct = idle_mix[p][1];
      for (int h = 0; h < 4; h++) hot_words[h] = $urandom_range(0, DEPTH - 1);
      ins_pct = (p == 3) ? 15 : 35;
      era_pct = (p == 3) ? 35 : 15;
      for (int n = 0; n < PHASE_ITEMS; n++) queue_beat(pick_cmd(ins_pct, era_pct), pick_key());
      if (p == 0) hold_trigger++;
      wait_drained();
    end

    // clear the set, then search it empty
    send_idle_pct = 29;
    recv_stall_pct = 29;
    for (int k = 0; k < DEPTH * WORD_W; k++) begin
      if (is_member(k)) queue_beat(CMD_ERASE, k);
    end
    for (int n = 0; n < 8; n++) queue_beat(pick_cmd(0, 0), pick_key());
    wait_drained();

    repeat (16) @(posedge clk_i);
    if (error_count == 0 && answer_q.size() == 0) begin
      $display("** hierarchical_bitmap_ordered_set: PASSED **");
    end else begin
      $display("** hierarchical_bitmap_ordered_set: FAILED **");
    end
    $finish;
  end

endmodule
